[sv/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, skipped while reset is held low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    `ASSERT_CLK(label, clk, rst_n, !(cond))

`endif

[sv/ss_pkg.sv]
package ss_pkg;

    localparam int KEY_BYTES = 16;
    localparam int KEY_W     = 8 * KEY_BYTES;
    localparam int LEN_W     = 5;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = 32;
    localparam int IDX_W     = 7;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 2'd2;

    localparam logic [LEN_W-1:0] KEY_LEN_RESET = 5'd1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
    } t_key_cfg;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] offset;
        logic             eos;
    } t_result;

    // Key byte at a given place; places beyond the stored key read as zero.
    function automatic logic [7:0] key_byte(logic [KEY_W-1:0] key, logic [IDX_W-1:0] idx);
        logic [7:0] b;
        b = '0;
        if (idx < IDX_W'(KEY_BYTES)) begin
            b = key[{idx[3:0], 3'b000} +: 8];
        end
        return b;
    endfunction

endpackage

[sv/ss_key_regs.sv]
module ss_key_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ss_pkg::CFG_W-1:0]      i_cfg_data,
    output ss_pkg::t_key_cfg              o_cfg
);
    import ss_pkg::*;

    logic [CFG_W-1:0] r_key_low;
    logic [CFG_W-1:0] r_key_high;
    logic [LEN_W-1:0] r_key_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_key_len  <= KEY_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                REG_KEY_LEN:  r_key_len  <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.key = {r_key_high, r_key_low};
    assign o_cfg.len = r_key_len;

endmodule

[sv/ss_matcher.sv]
module ss_matcher #(
    parameter int KEY_MAX = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic              i_fresh,
    input  ss_pkg::t_key_cfg  i_cfg,
    output logic              o_emit,
    output ss_pkg::t_result   o_result
);
    import ss_pkg::*;

    localparam int FW = $clog2(KEY_MAX + 1);
    localparam int CW = (FW > LEN_W) ? FW : LEN_W;

    logic [7:0]       r_win [KEY_MAX];
    logic [FW-1:0]    r_fill;
    logic [POS_W-1:0] r_pos;

    logic [7:0]       win_sh [KEY_MAX];
    logic [FW-1:0]    fill_base;
    logic [FW-1:0]    fill_inc;
    logic [POS_W-1:0] pos_base;
    logic [POS_W-1:0] pos_inc;
    logic [CW-1:0]    len_ext;
    logic [CW-1:0]    len_c;
    logic [CW-1:0]    idx;
    logic             hit;

    always_comb begin
        fill_base = i_fresh ? '0 : r_fill;
        pos_base  = i_fresh ? '0 : r_pos;
        // newest byte enters at entry 0; a new source flushes the old bytes
        win_sh[0] = i_byte;
        for (int k = 1; k < KEY_MAX; k++) begin
            win_sh[k] = i_fresh ? 8'h00 : r_win[k-1];
        end
        fill_inc = (fill_base == FW'(KEY_MAX)) ? fill_base : fill_base + 1'b1;
        pos_inc  = (pos_base == '1) ? pos_base : pos_base + 1'b1;

        len_ext = CW'(i_cfg.len);
        len_c   = (len_ext > CW'(KEY_MAX)) ? CW'(KEY_MAX) : len_ext;

        hit = (len_c != '0) && (CW'(fill_inc) >= len_c);
        idx = '0;
        for (int k = 0; k < KEY_MAX; k++) begin
            idx = len_c - 1'b1 - CW'(k);
            if (CW'(k) < len_c) begin
                if (win_sh[k] != key_byte(i_cfg.key, IDX_W'(idx))) begin
                    hit = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_MAX; k++) begin
                r_win[k] <= 8'h00;
            end
            r_fill <= '0;
            r_pos  <= '0;
        end else if (i_step) begin
            for (int k = 0; k < KEY_MAX; k++) begin
                r_win[k] <= hit ? 8'h00 : win_sh[k];
            end
            r_fill <= hit ? '0 : fill_inc;
            r_pos  <= pos_inc;
        end
    end

    assign o_emit          = hit | i_last;
    assign o_result.found  = hit;
    assign o_result.offset = hit ? pos_inc : '0;
    assign o_result.eos    = i_last;

endmodule

[sv/substring_search.sv]
// Exact key search over a byte stream.
// Input items (one source byte each) arrive on the s_axis group: tdata holds
// the byte, tlast marks the final byte of a source, tuser starts a new
// source (window and position cleared before that byte).
// Result items leave on the m_axis group: tdata is the position just past a
// match (zero when none), tuser is the found flag, tlast closes the source.
// A result is produced when the key matches at a byte or at a final byte;
// other bytes produce nothing. Matches never overlap.
// The key and its length are written through the cfg port while idle, a rule
// for the user, not enforced by the block. One item per cycle while the
// receiver does not stall; input register, then compare and result register.
// Reset (synchronous, active low) empties both registers, clears window and
// position, and sets the key to zero with length one.
// When the receiver stalls, the result register holds and s_axis tready
// drops only once the input register is also full.
module substring_search #(
    parameter int KEY_MAX = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ss_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,  // data_byte
    input  logic                          i_s_axis_tlast,  // last_byte
    input  logic                          i_s_axis_tuser,  // new_source
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [ss_pkg::POS_W-1:0]      o_m_axis_tdata,  // match_end_offset
    output logic                          o_m_axis_tlast,  // end_of_source
    output logic                          o_m_axis_tuser   // found
);
    import ss_pkg::*;

    t_key_cfg cfg;
    t_result  result;
    logic     emit;
    logic     advance;
    logic     step;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_in_fresh;
    logic       r_out_valid;
    t_result    r_out;

    ss_key_regs u_key_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ss_matcher #(.KEY_MAX(KEY_MAX)) u_matcher (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_fresh  (r_in_fresh),
        .i_cfg    (cfg),
        .o_emit   (emit),
        .o_result (result)
    );

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte  <= i_s_axis_tdata;
            r_in_last  <= i_s_axis_tlast;
            r_in_fresh <= i_s_axis_tuser;
        end
        if (step && emit) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.offset;
    assign o_m_axis_tlast  = r_out.eos;
    assign o_m_axis_tuser  = r_out.found;

endmodule

[sv/ss_checker.sv]
`include "assert_macros.svh"

module ss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic        o_m_axis_tuser
);

    // stalled result holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser))

    // an item without a match reports offset zero
    `ASSERT_NEVER(a_miss_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser && (o_m_axis_tdata != 32'd0))

    // a match ends at least one byte into the source
    `ASSERT_NEVER(a_hit_nonzero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser && (o_m_axis_tdata == 32'd0))

    // with the result register empty the input side never stalls
    `ASSERT_CLK(a_ready_free, i_clk, i_rst_n, !o_m_axis_tvalid |-> o_s_axis_tready)

endmodule

bind substring_search ss_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

[test/tb_substring_search.sv]
`timescale 1ns / 1ps

module tb_substring_search;
    import ss_pkg::*;

    localparam int SETTLE_CYCLES = 6;   // pipeline is two deep, leave some margin
    localparam int MAX_GAP       = 6;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       fresh;
    } t_src_item;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx    = REG_KEY_LOW;
    logic [CFG_W-1:0]     cfg_data   = '0;
    logic                 s_valid    = 1'b0;
    logic [7:0]           s_data     = '0;
    logic                 s_last     = 1'b0;
    logic                 s_user     = 1'b0;
    logic                 m_ready    = 1'b0;
    wire                  s_ready;
    wire                  m_valid;
    wire  [POS_W-1:0]     m_data;
    wire                  m_last;
    wire                  m_user;

    substring_search dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .o_m_axis_tuser  (m_user)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("tb_substring_search: FAIL");
        $finish;
    end

    // search model state, mirrors the block's registers
    logic [63:0]      key_lo_q  = '0;
    logic [63:0]      key_hi_q  = '0;
    logic [LEN_W-1:0] key_len_q = KEY_LEN_RESET;
    logic [7:0]       win [KEY_BYTES] = '{default: '0};
    int               win_fill  = 0;
    logic [POS_W-1:0] pos_q     = '0;

    t_src_item byte_queue [$];
    t_result   exp_results [$];
    int        err_count = 0;

    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;
    int   gap_left   = 0;
    int   stall_left = 0;
    bit   in_burst   = 1'b0;
    bit   out_burst  = 1'b0;

    function automatic logic [7:0] key_at(input int i);
        logic [127:0] k;
        k = {key_hi_q, key_lo_q};
        return k[8*i +: 8];
    endfunction

    function automatic void clear_window();
        foreach (win[k]) win[k] = '0;
        win_fill = 0;
    endfunction

    // Advance the search by one byte; returns 1 when the byte yields a result.
    function automatic bit search_step(input logic [7:0] b, input logic last,
                                       input logic fresh, output t_result r);
        int len;
        bit hit;
        if (fresh) begin
            clear_window();
            pos_q = '0;
        end
        for (int k = KEY_BYTES - 1; k > 0; k--) win[k] = win[k-1];
        win[0] = b;
        if (win_fill < KEY_BYTES) win_fill++;
        if (pos_q != '1) pos_q++;
        len = (key_len_q > KEY_BYTES) ? KEY_BYTES : int'(key_len_q);
        hit = (len != 0) && (win_fill >= len);
        // oldest window byte lines up with key byte 0
        for (int k = 0; k < len && hit; k++) begin
            if (win[k] != key_at(len - 1 - k)) hit = 1'b0;
        end
        if (hit) clear_window();
        r.found  = hit;
        r.offset = hit ? pos_q : '0;
        r.eos    = last;
        return hit || last;
    endfunction

    // check results first, then predict from the byte accepted at this edge
    always @(posedge i_clk) begin : scoreboard
        t_result want;
        t_result got;
        out_taken <= i_rst_n && m_valid && m_ready;
        in_taken  <= i_rst_n && s_valid && s_ready;
        if (i_rst_n && m_valid && m_ready) begin
            if (exp_results.size() == 0) begin
                $display("%0t: unexpected result found=%0b offset=%0d eos=%0b",
                         $time, m_user, m_data, m_last);
                err_count++;
            end else begin
                want = exp_results.pop_front();
                if (m_user !== want.found) begin
                    $display("%0t: found expected %0b actual %0b", $time, want.found, m_user);
                    err_count++;
                end
                if (m_data !== want.offset) begin
                    $display("%0t: offset expected %0d actual %0d", $time, want.offset, m_data);
                    err_count++;
                end
                if (m_last !== want.eos) begin
                    $display("%0t: eos expected %0b actual %0b", $time, want.eos, m_last);
                    err_count++;
                end
            end
        end
        if (i_rst_n && s_valid && s_ready) begin
            if (search_step(s_data, s_last, s_user, got)) exp_results.push_back(got);
        end
    end

    always @(negedge i_clk) begin : drive_bytes
        logic      v;
        t_src_item it;
        v = s_valid;
        if (v && in_taken) v = 1'b0;
        if (i_rst_n && !v) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (byte_queue.size() > 0) begin
                it = byte_queue.pop_front();
                s_data <= it.data;
                s_last <= it.last;
                s_user <= it.fresh;
                v = 1'b1;
                if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
                gap_left = in_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
        end
        s_valid <= v;
    end

    always @(negedge i_clk) begin : drive_ready
        if (out_taken) begin
            if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
            stall_left = out_burst ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic void push_byte(input logic [7:0] d, input logic l, input logic f);
        t_src_item it;
        it.data  = d;
        it.last  = l;
        it.fresh = f;
        byte_queue.push_back(it);
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            REG_KEY_LOW:  key_lo_q  = val;
            REG_KEY_HIGH: key_hi_q  = val;
            REG_KEY_LEN:  key_len_q = val[LEN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // bytes that give no result may still be in flight, hence the settle cycles
    task automatic wait_drained();
        do @(posedge i_clk);
        while (byte_queue.size() != 0 || s_valid || exp_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // New key, then sources built mostly from key copies and key bytes.
    task automatic run_phase(input logic [LEN_W-1:0] len, input int n_items);
        logic [7:0]  alpha [4] = '{8'h00, 8'hFF, 8'h61, 8'h62};
        logic [7:0]  kb [KEY_BYTES];
        logic [7:0]  src [$];
        logic [63:0] lo;
        logic [63:0] hi;
        int          eff;
        int          done;
        int          n;
        int          bad;
        bit          narrow;
        narrow = $urandom_range(0, 1);
        for (int i = 0; i < KEY_BYTES; i++) begin
            kb[i] = narrow ? alpha[$urandom_range(0, 3)] : 8'($urandom);
        end
        for (int i = 0; i < 8; i++) begin
            lo[8*i +: 8] = kb[i];
            hi[8*i +: 8] = kb[i+8];
        end
        cfg_write(REG_KEY_LOW, lo);
        cfg_write(REG_KEY_HIGH, hi);
        cfg_write(REG_KEY_LEN, CFG_W'(len));
        eff  = (len > KEY_BYTES) ? KEY_BYTES : int'(len);
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                push_byte(8'($urandom), 1'($urandom), 1'($urandom));
                done++;
            end else begin
                src.delete();
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
                while (src.size() < n) begin
                    if (eff > 0 && $urandom_range(0, 3) == 0) begin
                        // whole key, now and then with one byte flipped
                        bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, eff - 1) : -1;
                        for (int j = 0; j < eff; j++) begin
                            src.push_back((j == bad) ? kb[j] ^ (8'h01 << $urandom_range(0, 7))
                                                     : kb[j]);
                        end
                    end else if ($urandom_range(0, 1) == 0) begin
                        src.push_back(kb[$urandom_range(0, (eff > 0) ? eff - 1 : 0)]);
                    end else begin
                        src.push_back(8'($urandom));
                    end
                end
                foreach (src[j]) begin
                    push_byte(src[j], (j == src.size() - 1) && ($urandom_range(0, 6) != 0),
                              (j == 0) && ($urandom_range(0, 7) != 0));
                end
                done += src.size();
            end
        end
        wait_drained();
    endtask

    initial begin : stimulus
        logic [LEN_W-1:0] len;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset key: a single zero byte
        push_byte(8'h00, 1'b0, 1'b1);
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(8'h00, 1'b1, 1'b1);
        wait_drained();

        // full-length key holding zero and all-ones bytes
        cfg_write(REG_KEY_LOW, 64'hFF00_7F80_0102_0304);
        cfg_write(REG_KEY_HIGH, 64'h00FF_55AA_C33C_1E0F);
        cfg_write(REG_KEY_LEN, CFG_W'(5'd16));
        for (int i = 0; i < KEY_BYTES; i++) push_byte(key_at(i), i == KEY_BYTES - 1, i == 0);
        wait_drained();

        // zero length never matches
        cfg_write(REG_KEY_LEN, CFG_W'(5'd0));
        push_byte(8'h00, 1'b0, 1'b1);
        push_byte(8'h04, 1'b1, 1'b0);
        wait_drained();

        // "aa" in "aaa": no overlap; last byte keeps window and position
        cfg_write(REG_KEY_LOW, 64'h6161);
        cfg_write(REG_KEY_LEN, CFG_W'(5'd2));
        push_byte(8'h61, 1'b0, 1'b1);
        push_byte(8'h61, 1'b0, 1'b0);
        push_byte(8'h61, 1'b1, 1'b0);
        push_byte(8'h61, 1'b1, 1'b0);
        wait_drained();

        for (int p = 0; p < 9; p++) begin
            case (p)
                0:       len = 5'd1;
                1:       len = 5'd16;
                2:       len = 5'd0;
                3:       len = 5'd31;
                4:       len = 5'd17;
                default: len = LEN_W'($urandom_range(1, 16));
            endcase
            run_phase(len, 92);
        end

        if (err_count == 0) begin
            $display("tb_substring_search: PASS");
        end else begin
            $display("tb_substring_search: FAIL");
        end
        $finish;
    end

endmodule
